@@ src/bezier_point_evaluator_core_assert.svh @@
// Assertion macros shared by the curve evaluator RTL.
// Both expect a signal named clk, and BPE_ASSERT_IMPL also rst, in the including module.
`ifndef BEZIER_POINT_EVALUATOR_CORE_ASSERT_SVH
`define BEZIER_POINT_EVALUATOR_CORE_ASSERT_SVH

// Same-cycle implication, checked outside of reset.
`define BPE_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked during reset as well.
`define BPE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/bpe_pkg.sv @@
`timescale 1ns / 1ps

package bpe_pkg;

  // Default sizes of the coordinate and curve parameter fields
  localparam int COORD_WIDTH_DEF = 16;
  localparam int T_FRAC_BITS_DEF = 16;
  localparam int OPCODE_W        = 2;

  // Curve degree codes; every other code runs the cubic form
  localparam logic [OPCODE_W-1:0] OP_LINEAR = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_QUAD   = 2'd1;

  // Load enables of the back stages, one per register stage
  typedef struct packed {
    logic prod;
    logic pair;
    logic fin;
  } bpe_adv_t;

endpackage

@@ src/bpe_axis.sv @@
`timescale 1ns / 1ps

module bpe_axis #(
  parameter int COORD_WIDTH = bpe_pkg::COORD_WIDTH_DEF,
  parameter int T_FRAC_BITS = bpe_pkg::T_FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  bpe_pkg::bpe_adv_t             adv,
  input  logic [3*T_FRAC_BITS:0]        w0,
  input  logic [3*T_FRAC_BITS:0]        w1,
  input  logic [3*T_FRAC_BITS:0]        w2,
  input  logic [3*T_FRAC_BITS:0]        w3,
  input  logic signed [COORD_WIDTH-1:0] c0,
  input  logic signed [COORD_WIDTH-1:0] c1,
  input  logic signed [COORD_WIDTH-1:0] c2,
  input  logic signed [COORD_WIDTH-1:0] c3,
  output logic signed [COORD_WIDTH-1:0] point
);
  import bpe_pkg::*;

  localparam int WW = 3*T_FRAC_BITS + 1;
  localparam int PW = COORD_WIDTH + WW + 1;
  localparam logic [PW-1:0] HALF = PW'(1) << (3*T_FRAC_BITS - 1);

  logic [WW-1:0]          w [4];
  logic signed [COORD_WIDTH-1:0] c [4];
  logic signed [PW-1:0]   prod_next [4];
  logic signed [PW-1:0]   prod [4];
  logic signed [PW-1:0]   sum_a;
  logic signed [PW-1:0]   sum_b;
  logic signed [PW-1:0]   total;

  assign w[0] = w0;
  assign w[1] = w1;
  assign w[2] = w2;
  assign w[3] = w3;
  assign c[0] = c0;
  assign c[1] = c1;
  assign c[2] = c2;
  assign c[3] = c3;

  // Weight each control point; the signed product fits PW bits exactly
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      prod_next[i] = PW'(c[i]) * PW'($signed({1'b0, w[i]}));
    end
  end

  always_ff @(posedge clk) begin
    if (adv.prod) begin
      for (int i = 0; i < 4; i++) begin
        prod[i] <= prod_next[i];
      end
    end
  end

  // Add the terms in pairs
  always_ff @(posedge clk) begin
    if (adv.pair) begin
      sum_a <= prod[0] + prod[1];
      sum_b <= prod[2] + prod[3];
    end
  end

  // Final add with the rounding half, then drop the fraction bits
  assign total = sum_a + sum_b + $signed(HALF);

  always_ff @(posedge clk) begin
    if (adv.fin) begin
      point <= total[3*T_FRAC_BITS +: COORD_WIDTH];
    end
  end

endmodule

@@ src/bezier_point_evaluator_core.sv @@
`timescale 1ns / 1ps
// Bezier point evaluator: one 2D curve point per request.
// Request channel: req_valid / req_stall with opcode (0 linear, 1 quadratic,
// 2 or 3 cubic), four control points in signed Q4.12 and param_t in unsigned
// Q1.T_FRAC_BITS (values above 1.0 are clamped to 1.0).
// Result channel: res_valid / res_stall with point_x and point_y, rounded to
// nearest with halves going up.
// Throughput is one request per cycle while res_stall is low; the
// seven-stage multiplier pipeline (powers of t and 1-t, Bernstein weights,
// weighted products, two add stages) registers each request on its way to the result.
// Every stage holds a valid bit. When res_stall is high, the stages that
// hold data stay put while empty stages further up keep filling; req_stall
// rises only once every stage is occupied. No request is dropped or repeated.
// Reset clears all valid bits; the datapath needs no reset. Opcodes are
// decoded per request, so curves of different degree may be mixed freely.
`include "bezier_point_evaluator_core_assert.svh"

module bezier_point_evaluator_core #(
  parameter int COORD_WIDTH = bpe_pkg::COORD_WIDTH_DEF,
  parameter int T_FRAC_BITS = bpe_pkg::T_FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  output logic                          req_stall,
  input  logic [bpe_pkg::OPCODE_W-1:0]  opcode,
  input  logic signed [COORD_WIDTH-1:0] p0_x,
  input  logic signed [COORD_WIDTH-1:0] p0_y,
  input  logic signed [COORD_WIDTH-1:0] p1_x,
  input  logic signed [COORD_WIDTH-1:0] p1_y,
  input  logic signed [COORD_WIDTH-1:0] p2_x,
  input  logic signed [COORD_WIDTH-1:0] p2_y,
  input  logic signed [COORD_WIDTH-1:0] p3_x,
  input  logic signed [COORD_WIDTH-1:0] p3_y,
  input  logic [T_FRAC_BITS:0]          param_t,
  output logic                          res_valid,
  input  logic                          res_stall,
  output logic signed [COORD_WIDTH-1:0] point_x,
  output logic signed [COORD_WIDTH-1:0] point_y
);
  import bpe_pkg::*;

  localparam int TW = T_FRAC_BITS + 1;       // t and 1-t
  localparam int SW = 2*T_FRAC_BITS + 1;     // second powers
  localparam int WW = 3*T_FRAC_BITS + 1;     // third powers and weights
  localparam logic [TW-1:0] ONE  = TW'(1) << T_FRAC_BITS;
  localparam logic [WW+1:0] ONE3 = (WW+2)'(1) << (3*T_FRAC_BITS);

  // Pipeline control
  logic [7:1] vld;
  logic [8:1] rdy;
  bpe_adv_t   adv;

  // Stage 1: clamped t, u = 1 - t
  logic [TW-1:0]       t_sat;
  logic [TW-1:0]       t1, u1;
  logic [OPCODE_W-1:0] op1;
  logic signed [COORD_WIDTH-1:0] c1 [8];

  // Stage 2: second powers
  logic [2*TW-1:0]     uu_full, ut_full, tt_full;
  logic [SW-1:0]       uu2, ut2, tt2;
  logic [TW-1:0]       t2, u2;
  logic [OPCODE_W-1:0] op2;
  logic signed [COORD_WIDTH-1:0] c2 [8];

  // Stage 3: third powers
  logic [SW+TW-1:0]    uuu_full, uut_full, utt_full, ttt_full;
  logic [WW-1:0]       uuu3, uut3, utt3, ttt3;
  logic [SW-1:0]       uu3, ut3, tt3;
  logic [TW-1:0]       t3, u3;
  logic [OPCODE_W-1:0] op3;
  logic signed [COORD_WIDTH-1:0] c3 [8];

  // Stage 4: Bernstein weights on a common 3*T_FRAC_BITS scale
  logic [WW+1:0]       uut_x3, utt_x3;
  logic [WW-1:0]       w0_next, w1_next, w2_next, w3_next;
  logic [WW-1:0]       w0, w1, w2, w3;
  logic [WW+1:0]       wsum;
  logic signed [COORD_WIDTH-1:0] c4 [8];

  // A stage loads when it is empty or the stage below moves on
  always_comb begin
    rdy[8] = !res_stall;
    for (int k = 7; k >= 1; k--) begin
      rdy[k] = !vld[k] || rdy[k+1];
    end
  end

  assign req_stall = !rdy[1];
  assign res_valid = vld[7];
  assign adv.prod  = rdy[5];
  assign adv.pair  = rdy[6];
  assign adv.fin   = rdy[7];

  // Advance valid bits with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[1]) begin
        vld[1] <= req_valid;
      end
      for (int k = 2; k <= 7; k++) begin
        if (rdy[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // Stage 1: clamp t to 1.0 and capture the request
  assign t_sat = (param_t > ONE) ? ONE : param_t;

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      t1    <= t_sat;
      u1    <= ONE - t_sat;
      op1   <= opcode;
      c1[0] <= p0_x;
      c1[1] <= p0_y;
      c1[2] <= p1_x;
      c1[3] <= p1_y;
      c1[4] <= p2_x;
      c1[5] <= p2_y;
      c1[6] <= p3_x;
      c1[7] <= p3_y;
    end
  end

  // Stage 2: u^2, u*t, t^2
  assign uu_full = (2*TW)'(u1) * (2*TW)'(u1);
  assign ut_full = (2*TW)'(u1) * (2*TW)'(t1);
  assign tt_full = (2*TW)'(t1) * (2*TW)'(t1);

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      uu2 <= uu_full[SW-1:0];
      ut2 <= ut_full[SW-1:0];
      tt2 <= tt_full[SW-1:0];
      t2  <= t1;
      u2  <= u1;
      op2 <= op1;
      c2  <= c1;
    end
  end

  // Stage 3: u^3, u^2 t, u t^2, t^3
  assign uuu_full = (SW+TW)'(uu2) * (SW+TW)'(u2);
  assign uut_full = (SW+TW)'(uu2) * (SW+TW)'(t2);
  assign utt_full = (SW+TW)'(ut2) * (SW+TW)'(t2);
  assign ttt_full = (SW+TW)'(tt2) * (SW+TW)'(t2);

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      uuu3 <= uuu_full[WW-1:0];
      uut3 <= uut_full[WW-1:0];
      utt3 <= utt_full[WW-1:0];
      ttt3 <= ttt_full[WW-1:0];
      uu3  <= uu2;
      ut3  <= ut2;
      tt3  <= tt2;
      t3   <= t2;
      u3   <= u2;
      op3  <= op2;
      c3   <= c2;
    end
  end

  // Stage 4: pick the weights of the requested degree
  assign uut_x3 = {2'b00, uut3} + {1'b0, uut3, 1'b0};
  assign utt_x3 = {2'b00, utt3} + {1'b0, utt3, 1'b0};

  always_comb begin
    case (op3)
      OP_LINEAR: begin
        w0_next = {u3, {(2*T_FRAC_BITS){1'b0}}};
        w1_next = {t3, {(2*T_FRAC_BITS){1'b0}}};
        w2_next = '0;
        w3_next = '0;
      end
      OP_QUAD: begin
        w0_next = {uu3, {T_FRAC_BITS{1'b0}}};
        w1_next = {ut3[SW-2:0], {(T_FRAC_BITS+1){1'b0}}};
        w2_next = {tt3, {T_FRAC_BITS{1'b0}}};
        w3_next = '0;
      end
      default: begin
        w0_next = uuu3;
        w1_next = uut_x3[WW-1:0];
        w2_next = utt_x3[WW-1:0];
        w3_next = ttt3;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      w0 <= w0_next;
      w1 <= w1_next;
      w2 <= w2_next;
      w3 <= w3_next;
      c4 <= c3;
    end
  end

  assign wsum = {2'b00, w0} + {2'b00, w1} + {2'b00, w2} + {2'b00, w3};

  // Stages 5 to 7: weighted products, pair sums, final sum and rounding
  bpe_axis #(
    .COORD_WIDTH (COORD_WIDTH),
    .T_FRAC_BITS (T_FRAC_BITS)
  ) u_axis_x (
    .clk   (clk),
    .adv   (adv),
    .w0    (w0),
    .w1    (w1),
    .w2    (w2),
    .w3    (w3),
    .c0    (c4[0]),
    .c1    (c4[2]),
    .c2    (c4[4]),
    .c3    (c4[6]),
    .point (point_x)
  );

  bpe_axis #(
    .COORD_WIDTH (COORD_WIDTH),
    .T_FRAC_BITS (T_FRAC_BITS)
  ) u_axis_y (
    .clk   (clk),
    .adv   (adv),
    .w0    (w0),
    .w1    (w1),
    .w2    (w2),
    .w3    (w3),
    .c0    (c4[1]),
    .c1    (c4[3]),
    .c2    (c4[5]),
    .c3    (c4[7]),
    .point (point_y)
  );

  `BPE_ASSERT_IMPL(a_t_split, vld[1], (t1 <= ONE) && ((u1 + t1) == ONE), "t and 1-t do not add to one")
  `BPE_ASSERT_IMPL(a_weight_sum, vld[4], wsum == ONE3, "Bernstein weights do not sum to one")
  `BPE_ASSERT_IMPL(a_full_stall, (&vld) && res_stall, req_stall, "request taken into a full pipeline")
  `BPE_ASSERT_NEXT(a_rst_clear, rst, vld == '0, "valid bits not cleared by reset")

endmodule
